// ===== hw/rtl/bnb_pkg.sv =====
// Shared types and constants for the Bernoulli naive Bayes classifier.
package bnb_pkg;

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [15:0] POST_MAX = 16'hFFFF;

  typedef enum logic {
    REQ_TRAIN    = 1'b0,
    REQ_CLASSIFY = 1'b1
  } req_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR_STEP,     // clear one store entry (index = cls, feat)
    OP_LATCH,        // capture the request
    OP_TR_RD,        // read feature count of (label, feat)
    OP_TR_WR,        // write back incremented feature count
    OP_TR_CLS,       // bump class and total counters
    OP_CL_START,     // start class: load class count, kick prior divide
    OP_FT_RD,        // issue feature count read
    OP_FT_DIV,       // kick p divide
    OP_FT_MUL,       // score *= factor
    OP_CL_END,       // accumulate sum and best
    OP_POST_DIV,     // kick posterior divide
    OP_EMIT          // drive result strobe
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [5:0] cls;
    logic [5:0] feat;
  } bnb_cmd_t;

  typedef struct packed {
    logic div_done;
    logic cls_empty;
    logic bit_set;
  } bnb_sts_t;

endpackage

// ===== hw/rtl/bnb_div.sv =====
// Restoring radix-2 divider: quotient of num / den, one bit per cycle.
module bnb_div #(
  parameter int unsigned NUM_BITS = 48,
  parameter int unsigned DEN_BITS = 40
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quot
);

  localparam int unsigned CNT_BITS = $clog2(NUM_BITS + 1);

  logic [DEN_BITS:0]   rem;
  logic [NUM_BITS-1:0] dividend;
  logic [DEN_BITS-1:0] divisor;
  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic [DEN_BITS:0]   shifted;
  logic [DEN_BITS:0]   diff;

  assign shifted = {rem[DEN_BITS-1:0], dividend[NUM_BITS-1]};
  assign diff    = shifted - {1'b0, divisor};

  // Shift in one dividend bit and subtract when it fits.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        rem      <= '0;
        dividend <= num;
        divisor  <= den;
        quot     <= '0;
        cnt      <= CNT_BITS'(NUM_BITS);
      end else if (busy) begin
        dividend <= {dividend[NUM_BITS-2:0], 1'b0};
        if (!diff[DEN_BITS]) begin
          rem  <= diff;
          quot <= {quot[NUM_BITS-2:0], 1'b1};
        end else begin
          rem  <= shifted;
          quot <= {quot[NUM_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/bnb_datapath.sv =====
// Count stores, shared divider and multiplier, score accumulation.
module bnb_datapath #(
  parameter int unsigned NUM_FEATURES = 16,
  parameter int unsigned NUM_CLASSES  = 8,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  bnb_pkg::bnb_cmd_t cmd,
  input  logic              req_type,
  input  logic [15:0]       feature_bits,
  input  logic [2:0]        class_label,
  output bnb_pkg::bnb_sts_t sts,
  output logic [2:0]        predicted_class,
  output logic [15:0]       posterior,
  output logic              no_data,
  output logic              label_ok,
  output logic              is_classify
);

  localparam int unsigned CLS_BITS  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int unsigned FT_BITS   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
  localparam int unsigned DEPTH     = NUM_CLASSES * NUM_FEATURES;
  localparam int unsigned ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SUM_BITS  = 17 + CLS_BITS;
  localparam int unsigned DNUM_BITS = (COUNT_BITS + 16 > SUM_BITS + 16) ?
                                      COUNT_BITS + 16 : SUM_BITS + 16;
  localparam int unsigned DDEN_BITS = (COUNT_BITS > SUM_BITS) ? COUNT_BITS : SUM_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  // Feature count store, cleared by the controller's sweep after reset.
  logic [COUNT_BITS-1:0] feat_mem [DEPTH];
  logic [COUNT_BITS-1:0] feat_rd;
  logic [COUNT_BITS-1:0] class_counts [NUM_CLASSES];
  logic [COUNT_BITS-1:0] sample_total;

  logic [15:0]           bits;
  logic [2:0]            label;
  logic                  req_q;
  logic [COUNT_BITS-1:0] cc;
  logic [16:0]           score;
  logic [16:0]           best;
  logic [2:0]            best_class;
  logic [SUM_BITS-1:0]   sum;
  logic [16:0]           p;

  logic                  div_start;
  logic [DNUM_BITS-1:0]  div_num;
  logic [DDEN_BITS-1:0]  div_den;
  logic                  div_done;
  logic [DNUM_BITS-1:0]  div_quot;
  bnb_pkg::op_t          div_op;
  logic [16:0]           q_clamp;
  logic [16:0]           factor;
  logic [33:0]           prod;
  logic [ADDR_BITS-1:0]  addr;
  logic [CLS_BITS-1:0]   cidx;
  logic                  cmd_bit;

  assign cidx    = cmd.cls[CLS_BITS-1:0];
  assign addr    = ADDR_BITS'(cmd.cls * NUM_FEATURES + cmd.feat);
  assign cmd_bit = (cmd.feat < 6'd16) ? bits[cmd.feat[3:0]] : 1'b0;
  assign q_clamp = (div_quot > DNUM_BITS'(bnb_pkg::ONE_Q16)) ? bnb_pkg::ONE_Q16
                                                             : div_quot[16:0];
  assign factor  = cmd_bit ? p : (bnb_pkg::ONE_Q16 - p);
  assign prod    = score * factor;

  assign label_ok    = (32'(label) < NUM_CLASSES);
  assign is_classify = req_q;
  assign sts.div_done  = div_done;
  assign sts.cls_empty = (cc == '0);
  assign sts.bit_set   = cmd_bit;

  // Select the divider operands from the current command.
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (cmd.op)
      bnb_pkg::OP_CL_START: begin
        div_start = 1'b1;
        div_num   = DNUM_BITS'({class_counts[cidx], 16'h0});
        div_den   = DDEN_BITS'(sample_total);
      end
      bnb_pkg::OP_FT_DIV: begin
        div_start = 1'b1;
        div_num   = DNUM_BITS'({feat_rd, 16'h0});
        div_den   = DDEN_BITS'(cc);
      end
      bnb_pkg::OP_POST_DIV: begin
        div_start = 1'b1;
        div_num   = DNUM_BITS'({best, 16'h0});
        div_den   = DDEN_BITS'(sum);
      end
      default: ;
    endcase
  end

  bnb_div #(.NUM_BITS(DNUM_BITS), .DEN_BITS(DDEN_BITS)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Feature count memory: one shared address, read every cycle, written on a clear step or a train write-back.
  always_ff @(posedge clk) begin
    if (cmd.op == bnb_pkg::OP_CLR_STEP) begin
      feat_mem[addr] <= '0;
    end else if (cmd.op == bnb_pkg::OP_TR_WR) begin
      feat_mem[addr] <= (feat_rd == CNT_MAX) ? CNT_MAX : feat_rd + 1'b1;
    end
    feat_rd <= feat_mem[addr];
  end

  // Counters, request capture and score bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CLASSES; i++) class_counts[i] <= '0;
      sample_total <= '0;
      req_q        <= 1'b0;
      div_op       <= bnb_pkg::OP_NONE;
    end else begin
      case (cmd.op)
        bnb_pkg::OP_LATCH: begin
          req_q <= req_type;
          bits  <= feature_bits;
          label <= class_label;
          sum   <= '0;
          best  <= '0;
          best_class <= '0;
        end
        bnb_pkg::OP_TR_CLS: begin
          if (class_counts[cidx] != CNT_MAX) class_counts[cidx] <= class_counts[cidx] + 1'b1;
          if (sample_total != CNT_MAX) sample_total <= sample_total + 1'b1;
        end
        bnb_pkg::OP_CL_START: cc <= class_counts[cidx];
        bnb_pkg::OP_FT_MUL:   score <= prod[32:16];
        bnb_pkg::OP_CL_END: begin
          if (cc != '0) begin
            sum <= sum + SUM_BITS'(score);
            if (score > best) begin
              best       <= score;
              best_class <= 3'(cmd.cls);
            end
          end
        end
        default: ;
      endcase
      // Note which divide is running, then route its quotient.
      if (div_start) div_op <= cmd.op;
      if (div_done) begin
        if (div_op == bnb_pkg::OP_CL_START) score <= q_clamp;
        if (div_op == bnb_pkg::OP_FT_DIV) p <= q_clamp;
      end
    end
  end

  // Result fields, valid when the controller emits.
  always_comb begin
    predicted_class = best_class;
    no_data         = (sum == '0);
    posterior       = (sum == '0) ? 16'h0 :
                      ((div_quot > DNUM_BITS'(bnb_pkg::POST_MAX)) ? bnb_pkg::POST_MAX
                                                                  : div_quot[15:0]);
  end

endmodule

// ===== hw/rtl/bnb_ctrl.sv =====
// Controller: clearing sweep, training and classification sequencing.
module bnb_ctrl #(
  parameter int unsigned NUM_FEATURES = 16,
  parameter int unsigned NUM_CLASSES  = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [4:0]        nf,
  input  bnb_pkg::bnb_sts_t sts,
  input  logic              label_ok,
  input  logic              is_classify,
  input  logic [2:0]        label,
  output bnb_pkg::bnb_cmd_t cmd,
  output logic              busy,
  output logic              done
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_TR_RD, S_TR_WAIT, S_TR_WR, S_TR_CLS,
    S_CL_START, S_CL_PRIOR, S_FT_RD, S_FT_DIV, S_FT_WAIT, S_FT_MUL,
    S_CL_END, S_POST, S_EMIT
  } state_t;

  state_t     state;
  logic [5:0] cls;
  logic [5:0] feat;
  logic [5:0] nf_act;

  assign nf_act = (32'(nf) > NUM_FEATURES) ? 6'(NUM_FEATURES) : 6'(nf);
  assign busy   = (state != S_IDLE);

  // Command decode by state.
  always_comb begin
    cmd.cls  = cls;
    cmd.feat = feat;
    unique case (state)
      S_CLR:      cmd.op = bnb_pkg::OP_CLR_STEP;
      S_IDLE:     cmd.op = start ? bnb_pkg::OP_LATCH : bnb_pkg::OP_NONE;
      S_TR_RD:    cmd.op = bnb_pkg::OP_TR_RD;
      S_TR_WR:    cmd.op = sts.bit_set ? bnb_pkg::OP_TR_WR : bnb_pkg::OP_NONE;
      S_TR_CLS:   cmd.op = bnb_pkg::OP_TR_CLS;
      S_CL_START: cmd.op = bnb_pkg::OP_CL_START;
      S_FT_RD:    cmd.op = bnb_pkg::OP_FT_RD;
      S_FT_DIV:   cmd.op = bnb_pkg::OP_FT_DIV;
      S_FT_MUL:   cmd.op = bnb_pkg::OP_FT_MUL;
      S_CL_END:   cmd.op = bnb_pkg::OP_CL_END;
      S_POST:     cmd.op = (cls == 6'd0) ? bnb_pkg::OP_POST_DIV : bnb_pkg::OP_NONE;
      S_EMIT:     cmd.op = bnb_pkg::OP_EMIT;
      default:    cmd.op = bnb_pkg::OP_NONE;
    endcase
  end

  // Sequence state and loop counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cls   <= '0;
      feat  <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLR: begin
          if (feat == 6'(NUM_FEATURES - 1)) begin
            feat <= '0;
            if (cls == 6'(NUM_CLASSES - 1)) begin
              cls   <= '0;
              state <= S_IDLE;
            end else cls <= cls + 1'b1;
          end else feat <= feat + 1'b1;
        end
        S_IDLE: if (start) state <= S_DEC;
        S_DEC: begin
          feat <= '0;
          cls  <= is_classify ? 6'd0 : 6'(label);
          if (is_classify) state <= S_CL_START;
          else if (!label_ok) state <= S_IDLE;
          else if (nf_act == '0) state <= S_TR_CLS;
          else state <= S_TR_RD;
        end
        S_TR_RD:   state <= S_TR_WAIT;
        S_TR_WAIT: state <= S_TR_WR;
        S_TR_WR: begin
          if (feat + 1'b1 == nf_act) state <= S_TR_CLS;
          else begin
            feat  <= feat + 1'b1;
            state <= S_TR_RD;
          end
        end
        S_TR_CLS: state <= S_IDLE;
        S_CL_START: begin
          feat  <= '0;
          state <= S_CL_PRIOR;
        end
        S_CL_PRIOR: begin
          if (sts.cls_empty) state <= S_CL_END;
          else if (sts.div_done) state <= (nf_act == '0) ? S_CL_END : S_FT_RD;
        end
        S_FT_RD:   state <= S_FT_DIV;
        S_FT_DIV:  state <= S_FT_WAIT;
        S_FT_WAIT: if (sts.div_done) state <= S_FT_MUL;
        S_FT_MUL: begin
          if (feat + 1'b1 == nf_act) state <= S_CL_END;
          else begin
            feat  <= feat + 1'b1;
            state <= S_FT_RD;
          end
        end
        S_CL_END: begin
          if (cls == 6'(NUM_CLASSES - 1)) begin
            cls   <= '0;
            state <= S_POST;
          end else begin
            cls   <= cls + 1'b1;
            state <= S_CL_START;
          end
        end
        S_POST: begin
          cls <= 6'd1;
          if (cls != 6'd0 && sts.div_done) begin
            done  <= 1'b1;
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          cls   <= '0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bernoulli_naive_bayes.sv =====
// Top level of the Bernoulli naive Bayes classifier.
// Bernoulli naive Bayes classifier. Raise start with an item while busy is
// low. A train item keeps busy high while it reads each feature in use,
// counts the set ones and its class (an out-of-range label is dropped), and
// gives no result. A classify item walks every class: one prior divide, then
// per feature a read, a bit-serial divide and a multiply; a class with no
// samples skips the feature steps. The result shows for one cycle with
// result_valid and cannot be held off. After reset busy stays high while
// the controller sweeps the feature count store clear; configuration writes
// are always taken.
module bernoulli_naive_bayes #(
  parameter int unsigned NUM_FEATURES = 16,
  parameter int unsigned NUM_CLASSES  = 8,
  parameter int unsigned COUNT_BITS   = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        req_type,
  input  logic [15:0] feature_bits,
  input  logic [2:0]  class_label,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        result_valid,
  output logic [2:0]  predicted_class,
  output logic [15:0] posterior,
  output logic        no_data
);

  logic [4:0]        features_in_use;
  bnb_pkg::bnb_cmd_t cmd;
  bnb_pkg::bnb_sts_t sts;
  logic              label_ok;
  logic              is_classify;
  logic [2:0]        class_label_q;

  assign cfg_ready = 1'b1;

  // Hold the feature count register.
  always_ff @(posedge clk) begin
    if (rst) features_in_use <= 5'd16;
    else if (cfg_valid && cfg_ready) features_in_use <= cfg_data;
  end

  // Hold the label of the accepted item for the controller.
  always_ff @(posedge clk) begin
    if (start && !busy) class_label_q <= class_label;
  end

  bnb_ctrl #(.NUM_FEATURES(NUM_FEATURES), .NUM_CLASSES(NUM_CLASSES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .nf          (features_in_use),
    .sts         (sts),
    .label_ok    (label_ok),
    .is_classify (is_classify),
    .label       (class_label_q),
    .cmd         (cmd),
    .busy        (busy),
    .done        (result_valid)
  );

  bnb_datapath #(
    .NUM_FEATURES(NUM_FEATURES), .NUM_CLASSES(NUM_CLASSES), .COUNT_BITS(COUNT_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req_type        (req_type),
    .feature_bits    (feature_bits),
    .class_label     (class_label),
    .sts             (sts),
    .predicted_class (predicted_class),
    .posterior       (posterior),
    .no_data         (no_data),
    .label_ok        (label_ok),
    .is_classify     (is_classify)
  );

  // A result never appears while the block is idle.
  assert property (@(posedge clk) disable iff (rst) result_valid |-> busy)
    else $error("result strobe while idle");
  // A result is a single-cycle strobe.
  assert property (@(posedge clk) disable iff (rst) result_valid |=> !result_valid)
    else $error("result strobe held");
  // No data means zero posterior and class 0.
  assert property (@(posedge clk) disable iff (rst)
    result_valid && no_data |-> posterior == 16'h0 && predicted_class == 3'h0)
    else $error("empty result carries data");

endmodule
